[sv/elgamal_modexp_cipher_defines.svh]
// Assertion macros shared by the ElGamal engine RTL.
`ifndef ELGAMAL_MODEXP_CIPHER_DEFINES_SVH
`define ELGAMAL_MODEXP_CIPHER_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define EMC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define EMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/emc_pkg.sv]
// Shared types, codes and the microcode program of the ElGamal engine.
`default_nettype none

package emc_pkg;

    // Fixed width of the item and result fields
    localparam int FIELD_W = 16;
    // Microcode address width
    localparam int PC_W = 5;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODULUS   = 2'd0,
        CFG_GENERATOR = 2'd1,
        CFG_PRIVATE   = 2'd2,
        CFG_PUBLIC    = 2'd3
    } cfg_index_t;

    // Microcode operation
    typedef enum logic [1:0] {
        UOP_NOP,
        UOP_MUL,
        UOP_SHIFT,
        UOP_OUT
    } uop_t;

    // Jump condition
    typedef enum logic [2:0] {
        JC_NONE,
        JC_BAD,
        JC_DECRYPT,
        JC_BIT_CLR,
        JC_MORE
    } jcond_t;

    // Multiplier operand source (bits scanned, any value)
    typedef enum logic [3:0] {
        MS_RA,
        MS_RB,
        MS_RC,
        MS_RD,
        MS_GEN,
        MS_PUB,
        MS_MSG,
        MS_C1,
        MS_C2
    } msrc_t;

    // Addend operand source (always below the modulus)
    typedef enum logic [2:0] {
        AS_ONE,
        AS_RA,
        AS_RB,
        AS_RC,
        AS_RD
    } asrc_t;

    // Product destination
    typedef enum logic [1:0] {
        DST_RA,
        DST_RB,
        DST_RC,
        DST_RD
    } dst_t;

    // Sequencer state
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_WAIT
    } seq_state_t;

    // One control word
    typedef struct packed {
        uop_t              op;
        jcond_t            cond;
        logic [PC_W-1:0]   target;
        msrc_t             src_m;
        asrc_t             src_a;
        dst_t              dst;
    } uword_t;

    // Datapath control from the sequencer
    typedef struct packed {
        logic   mul_start;
        logic   mul_write;
        logic   shift;
        logic   emit;
        msrc_t  src_m;
        asrc_t  src_a;
        dst_t   dst;
    } dp_ctrl_t;

    // Datapath status to the sequencer
    typedef struct packed {
        logic bad;
        logic decrypt;
        logic exp_bit;
        logic last;
        logic mul_done;
    } dp_stat_t;

    // Program labels
    localparam logic [PC_W-1:0] L_ELOOP = 5'd4;
    localparam logic [PC_W-1:0] L_ESQ   = 5'd7;
    localparam logic [PC_W-1:0] L_OUT   = 5'd11;
    localparam logic [PC_W-1:0] L_DEC   = 5'd12;
    localparam logic [PC_W-1:0] L_DLOOP = 5'd13;
    localparam logic [PC_W-1:0] L_DSQ   = 5'd15;

    // Build one control word
    function automatic uword_t uw(input uop_t op, input jcond_t jc,
                                  input logic [PC_W-1:0] tgt, input msrc_t m,
                                  input asrc_t a, input dst_t d);
        uword_t w;
        w.op     = op;
        w.cond   = jc;
        w.target = tgt;
        w.src_m  = m;
        w.src_a  = a;
        w.dst    = d;
        return w;
    endfunction

    // Program: encrypt runs g^k and y^k side by side then m, decrypt runs c1^e then c2
    function automatic uword_t emc_rom(input logic [PC_W-1:0] addr);
        uword_t w;
        case (addr)
            5'd0:  w = uw(UOP_NOP,   JC_BAD,     L_OUT,   MS_RA,  AS_ONE, DST_RA);
            5'd1:  w = uw(UOP_NOP,   JC_DECRYPT, L_DEC,   MS_RA,  AS_ONE, DST_RA);
            5'd2:  w = uw(UOP_MUL,   JC_NONE,    '0,      MS_GEN, AS_ONE, DST_RB);
            5'd3:  w = uw(UOP_MUL,   JC_NONE,    '0,      MS_PUB, AS_ONE, DST_RD);
            5'd4:  w = uw(UOP_NOP,   JC_BIT_CLR, L_ESQ,   MS_RA,  AS_ONE, DST_RA);
            5'd5:  w = uw(UOP_MUL,   JC_NONE,    '0,      MS_RA,  AS_RB,  DST_RA);
            5'd6:  w = uw(UOP_MUL,   JC_NONE,    '0,      MS_RC,  AS_RD,  DST_RC);
            5'd7:  w = uw(UOP_MUL,   JC_NONE,    '0,      MS_RB,  AS_RB,  DST_RB);
            5'd8:  w = uw(UOP_MUL,   JC_NONE,    '0,      MS_RD,  AS_RD,  DST_RD);
            5'd9:  w = uw(UOP_SHIFT, JC_MORE,    L_ELOOP, MS_RA,  AS_ONE, DST_RA);
            5'd10: w = uw(UOP_MUL,   JC_NONE,    '0,      MS_MSG, AS_RC,  DST_RC);
            5'd11: w = uw(UOP_OUT,   JC_NONE,    '0,      MS_RA,  AS_ONE, DST_RA);
            5'd12: w = uw(UOP_MUL,   JC_NONE,    '0,      MS_C1,  AS_ONE, DST_RB);
            5'd13: w = uw(UOP_NOP,   JC_BIT_CLR, L_DSQ,   MS_RA,  AS_ONE, DST_RA);
            5'd14: w = uw(UOP_MUL,   JC_NONE,    '0,      MS_RA,  AS_RB,  DST_RA);
            5'd15: w = uw(UOP_MUL,   JC_NONE,    '0,      MS_RB,  AS_RB,  DST_RB);
            5'd16: w = uw(UOP_SHIFT, JC_MORE,    L_DLOOP, MS_RA,  AS_ONE, DST_RA);
            5'd17: w = uw(UOP_MUL,   JC_NONE,    '0,      MS_C2,  AS_RA,  DST_RA);
            default: w = uw(UOP_OUT, JC_NONE,    '0,      MS_RA,  AS_ONE, DST_RA);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[sv/emc_mulmod.sv]
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`default_nettype none
`include "elgamal_modexp_cipher_defines.svh"

module emc_mulmod #(
    parameter int MOD_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [MOD_BITS-1:0] multiplier,
    input  wire logic [MOD_BITS-1:0] addend,
    input  wire logic [MOD_BITS-1:0] modulus,
    output logic                     done,
    output logic [MOD_BITS-1:0]      product
);

    localparam int EW    = MOD_BITS + 2;
    localparam int CNT_W = $clog2(MOD_BITS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] mreg_reg, mreg_next;
    logic [MOD_BITS-1:0] areg_reg, areg_next;
    logic [EW-1:0]       sum;
    logic [EW-1:0]       p1;
    logic [EW-1:0]       p2;
    logic [EW-1:0]       red;

    // Double, add on a set bit, then drop zero, one or two moduli
    always_comb
    begin
        p1  = EW'(modulus);
        p2  = EW'({modulus, 1'b0});
        sum = {1'b0, acc_reg, 1'b0} + (mreg_reg[MOD_BITS-1] ? EW'(areg_reg) : '0);
        if (sum >= p2)
        begin
            red = sum - p2;
        end
        else if (sum >= p1)
        begin
            red = sum - p1;
        end
        else
        begin
            red = sum;
        end
    end

    // Advance the iteration
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mreg_next = mreg_reg;
        areg_next = areg_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MOD_BITS);
            acc_next  = '0;
            mreg_next = multiplier;
            areg_next = addend;
        end
        else if (busy_reg)
        begin
            acc_next  = red[MOD_BITS-1:0];
            mreg_next = {mreg_reg[MOD_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands and the partial product
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        mreg_reg <= mreg_next;
        areg_reg <= areg_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

    `EMC_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy_reg, busy_reg, "multiply did not start")
    `EMC_ASSERT_SAME(a_done_idle, clk, rst_n, done_reg, !busy_reg, "multiply done while still busy")

endmodule

`default_nettype wire

[sv/emc_sequencer.sv]
// Microcode sequencer: step counter, program fetch and conditional jumps.
`default_nettype none

module emc_sequencer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire emc_pkg::dp_stat_t stat,
    output emc_pkg::dp_ctrl_t      ctrl,
    output logic                   busy
);

    import emc_pkg::*;

    seq_state_t      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          word;
    logic            taken;

    // Fetch the current control word
    assign word = emc_rom(pc_reg);

    // Evaluate the jump condition
    always_comb
    begin
        case (word.cond)
            JC_BAD:     taken = stat.bad;
            JC_DECRYPT: taken = stat.decrypt;
            JC_BIT_CLR: taken = !stat.exp_bit;
            JC_MORE:    taken = !stat.last;
            default:    taken = 1'b0;
        endcase
    end

    // Next state and step counter
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = SEQ_RUN;
                    pc_next    = '0;
                end
            end
            SEQ_RUN:
            begin
                case (word.op)
                    UOP_MUL:
                    begin
                        state_next = SEQ_WAIT;
                    end
                    UOP_OUT:
                    begin
                        state_next = SEQ_IDLE;
                    end
                    default:
                    begin
                        pc_next = taken ? word.target : pc_reg + PC_W'(1);
                    end
                endcase
            end
            SEQ_WAIT:
            begin
                if (stat.mul_done)
                begin
                    state_next = SEQ_RUN;
                    pc_next    = pc_reg + PC_W'(1);
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Drive datapath controls
    always_comb
    begin
        ctrl.mul_start = 1'b0;
        ctrl.mul_write = 1'b0;
        ctrl.shift     = 1'b0;
        ctrl.emit      = 1'b0;
        ctrl.src_m     = word.src_m;
        ctrl.src_a     = word.src_a;
        ctrl.dst       = word.dst;
        case (state_reg)
            SEQ_RUN:
            begin
                ctrl.mul_start = (word.op == UOP_MUL);
                ctrl.shift     = (word.op == UOP_SHIFT);
                ctrl.emit      = (word.op == UOP_OUT);
            end
            SEQ_WAIT:
            begin
                ctrl.mul_write = stat.mul_done;
            end
            default:
            begin
                ctrl.mul_start = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != SEQ_IDLE);

    // Hold state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

`default_nettype wire

[sv/emc_datapath.sv]
// Datapath: working registers, exponent shifter and result registers.
`default_nettype none

module emc_datapath #(
    parameter int MOD_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic                         command,
    input  wire logic [emc_pkg::FIELD_W-1:0]  message,
    input  wire logic [emc_pkg::FIELD_W-1:0]  ephemeral_key,
    input  wire logic [emc_pkg::FIELD_W-1:0]  cipher_first,
    input  wire logic [emc_pkg::FIELD_W-1:0]  cipher_second,
    input  wire logic [MOD_BITS-1:0]          modulus,
    input  wire logic [MOD_BITS-1:0]          generator,
    input  wire logic [MOD_BITS-1:0]          private_key,
    input  wire logic [MOD_BITS-1:0]          public_key,
    input  wire emc_pkg::dp_ctrl_t            ctrl,
    output emc_pkg::dp_stat_t                 stat,
    output logic [emc_pkg::FIELD_W-1:0]       result_first,
    output logic [emc_pkg::FIELD_W-1:0]       result_second,
    output logic                              status,
    output logic                              done
);

    import emc_pkg::*;

    localparam int CNT_W = $clog2(MOD_BITS + 1);

    logic                bad_reg;
    logic                cmd_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                done_reg;
    logic [MOD_BITS-1:0] exp_reg;
    logic [MOD_BITS-1:0] msg_reg;
    logic [MOD_BITS-1:0] c1_reg;
    logic [MOD_BITS-1:0] c2_reg;
    logic [MOD_BITS-1:0] ra_reg;
    logic [MOD_BITS-1:0] rb_reg;
    logic [MOD_BITS-1:0] rc_reg;
    logic [MOD_BITS-1:0] rd_reg;
    logic [FIELD_W-1:0]  res1_reg;
    logic [FIELD_W-1:0]  res2_reg;
    logic                st_reg;
    logic                bad_cfg;
    logic [MOD_BITS-1:0] dec_exp;
    logic [MOD_BITS-1:0] op_m;
    logic [MOD_BITS-1:0] op_a;
    logic                mul_done;
    logic [MOD_BITS-1:0] product;

    // Check the configuration and form the decrypt exponent p-1-x
    assign bad_cfg = (modulus < MOD_BITS'(3)) || (private_key > modulus - MOD_BITS'(2));
    assign dec_exp = modulus - MOD_BITS'(1) - private_key;

    // Select the scanned operand
    always_comb
    begin
        case (ctrl.src_m)
            MS_RA:   op_m = ra_reg;
            MS_RB:   op_m = rb_reg;
            MS_RC:   op_m = rc_reg;
            MS_RD:   op_m = rd_reg;
            MS_GEN:  op_m = generator;
            MS_PUB:  op_m = public_key;
            MS_MSG:  op_m = msg_reg;
            MS_C1:   op_m = c1_reg;
            MS_C2:   op_m = c2_reg;
            default: op_m = '0;
        endcase
    end

    // Select the reduced operand
    always_comb
    begin
        case (ctrl.src_a)
            AS_ONE:  op_a = MOD_BITS'(1);
            AS_RA:   op_a = ra_reg;
            AS_RB:   op_a = rb_reg;
            AS_RC:   op_a = rc_reg;
            AS_RD:   op_a = rd_reg;
            default: op_a = '0;
        endcase
    end

    emc_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (ctrl.mul_start),
        .multiplier (op_m),
        .addend     (op_a),
        .modulus    (modulus),
        .done       (mul_done),
        .product    (product)
    );

    // Report status to the sequencer
    always_comb
    begin
        stat.bad      = bad_reg;
        stat.decrypt  = cmd_reg;
        stat.exp_bit  = exp_reg[0];
        stat.last     = (cnt_reg == CNT_W'(1));
        stat.mul_done = mul_done;
    end

    // Hold control flags and the loop count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_reg  <= 1'b0;
            cmd_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.emit;
            if (accept)
            begin
                bad_reg <= bad_cfg;
                cmd_reg <= command;
                cnt_reg <= CNT_W'(MOD_BITS);
            end
            else if (ctrl.shift)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Load the request, shift the exponent, write products, capture results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            msg_reg <= MOD_BITS'(message);
            c1_reg  <= MOD_BITS'(cipher_first);
            c2_reg  <= MOD_BITS'(cipher_second);
            exp_reg <= command ? dec_exp : MOD_BITS'(ephemeral_key);
            ra_reg  <= MOD_BITS'(1);
            rc_reg  <= MOD_BITS'(1);
        end
        else
        begin
            if (ctrl.shift)
            begin
                exp_reg <= exp_reg >> 1;
            end
            if (ctrl.mul_write)
            begin
                case (ctrl.dst)
                    DST_RA:  ra_reg <= product;
                    DST_RB:  rb_reg <= product;
                    DST_RC:  rc_reg <= product;
                    DST_RD:  rd_reg <= product;
                    default: ra_reg <= product;
                endcase
            end
        end
        if (ctrl.emit)
        begin
            res1_reg <= bad_reg ? '0 : FIELD_W'(ra_reg);
            res2_reg <= (bad_reg || cmd_reg) ? '0 : FIELD_W'(rc_reg);
            st_reg   <= bad_reg;
        end
    end

    assign result_first  = res1_reg;
    assign result_second = res2_reg;
    assign status        = st_reg;
    assign done          = done_reg;

endmodule

`default_nettype wire

[sv/elgamal_modexp_cipher.sv]
// Top level of the ElGamal engine: configuration registers, sequencer, datapath.
// W = MOD_BITS; every multiply runs in the single shared multiplier unit. Per request:
//   encrypt scans all W key bits, multiplying in g and y powers on set bits, then m.
//   decrypt scans all W bits of p-1-x, multiplying in c1 powers on set bits, then c2.
// One request at a time: busy stays high until the result strobe; done lasts one cycle.
// A bad configuration skips every multiply. Reset loads the default key set and idles.
`default_nettype none
`include "elgamal_modexp_cipher_defines.svh"

module elgamal_modexp_cipher #(
    parameter int MOD_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire emc_pkg::cfg_index_t         cfg_index,
    input  wire logic [MOD_BITS-1:0]         cfg_data,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        command,
    input  wire logic [emc_pkg::FIELD_W-1:0] message,
    input  wire logic [emc_pkg::FIELD_W-1:0] ephemeral_key,
    input  wire logic [emc_pkg::FIELD_W-1:0] cipher_first,
    input  wire logic [emc_pkg::FIELD_W-1:0] cipher_second,
    output logic                             done,
    output logic [emc_pkg::FIELD_W-1:0]      result_first,
    output logic [emc_pkg::FIELD_W-1:0]      result_second,
    output logic                             status
);

    import emc_pkg::*;

    logic [MOD_BITS-1:0] modulus_reg;
    logic [MOD_BITS-1:0] generator_reg;
    logic [MOD_BITS-1:0] private_reg;
    logic [MOD_BITS-1:0] public_reg;
    logic                accept;
    logic                seq_busy;
    dp_ctrl_t            ctrl;
    dp_stat_t            stat;

    assign accept = start && !seq_busy;
    assign busy   = seq_busy;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= MOD_BITS'(65521);
            generator_reg <= MOD_BITS'(2);
            private_reg   <= MOD_BITS'(1);
            public_reg    <= MOD_BITS'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODULUS:   modulus_reg   <= cfg_data;
                CFG_GENERATOR: generator_reg <= cfg_data;
                CFG_PRIVATE:   private_reg   <= cfg_data;
                CFG_PUBLIC:    public_reg    <= cfg_data;
                default:       modulus_reg   <= modulus_reg;
            endcase
        end
    end

    emc_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .stat   (stat),
        .ctrl   (ctrl),
        .busy   (seq_busy)
    );

    emc_datapath #(
        .MOD_BITS (MOD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .command       (command),
        .message       (message),
        .ephemeral_key (ephemeral_key),
        .cipher_first  (cipher_first),
        .cipher_second (cipher_second),
        .modulus       (modulus_reg),
        .generator     (generator_reg),
        .private_key   (private_reg),
        .public_key    (public_reg),
        .ctrl          (ctrl),
        .stat          (stat),
        .result_first  (result_first),
        .result_second (result_second),
        .status        (status),
        .done          (done)
    );

    `EMC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "request accepted but not busy")
    `EMC_ASSERT_SAME(a_done_after_busy, clk, rst_n, done, $past(busy), "result without a running request")

endmodule

`default_nettype wire
